// File: rtl/efrs_pkg.sv
// Shared constants and types for the earliest-free-room scheduler.
// No dependencies; used by earliest_free_room_scheduler_top.
package efrs_pkg;

	localparam int ROOMS_DEF     = 16;
	localparam int TIME_BITS_DEF = 40;
	localparam int CNT_BITS      = 32;
	localparam int CFG_BITS      = 5;
	localparam int SZ_BITS       = 8;

	localparam logic [CFG_BITS-1:0] NUM_ROOMS_RST = 5'd16;
	localparam logic [CNT_BITS-1:0] CNT_MAX       = '1;
	localparam logic [63:0]         ALL_ONES_64   = '1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_PICK  = 5'b01000,
		ST_UPD   = 5'b10000
	} state_t;

endpackage

// File: rtl/earliest_free_room_scheduler_top.sv
// Earliest-free-room scheduler: room free times and job counts in two memories.
// Depends on efrs_pkg.
//
// Usage: jobs enter on the input channel (in_valid / in_stall) in nondecreasing
// start order, one word per job. Each job is placed in the lowest room free at
// its start, or else in the room that frees first, delayed to that time. One
// result word per job leaves on the output channel (out_valid / out_stall).
// The user must write the room count on the cfg channel (cfg_valid / cfg_ready)
// only while idle; the block does not enforce this. cfg_ready is always high.
// Flow: an accepted job passes through the scan, drain, pick and update states;
// its result is loaded in the update state, and the next job is accepted once
// the block is idle again. The loop that sets this is the scan of the free-time
// and job-count memories, one room per cycle via a single read port of each.
// A stalled result is held in the output register; a finished job waits for it
// to drain before it writes back, and no new job is taken meanwhile.
// Reset clears all rooms at once through per-room valid bits, sets the room
// count to 16 and empties the output register. The job marked last also
// reports the busiest room and clears the valid bits for the next batch.
module earliest_free_room_scheduler_top #(
	parameter int ROOMS     = efrs_pkg::ROOMS_DEF,
	parameter int TIME_BITS = efrs_pkg::TIME_BITS_DEF,
	localparam int ROOM_BITS = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [efrs_pkg::CFG_BITS-1:0] num_rooms,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   start_time,
	input  logic [31:0]                   end_time,
	input  logic                          last_meeting,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ROOM_BITS-1:0]          assigned_room,
	output logic [TIME_BITS-1:0]          begin_time,
	output logic [TIME_BITS-1:0]          finish_time,
	output logic [ROOM_BITS-1:0]          busiest_room,
	output logic                          batch_done
);

	localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
	localparam logic [63:0] TIME_MAX64 = efrs_pkg::ALL_ONES_64 >> (64 - TIME_BITS);
	localparam logic [TIME_BITS-1:0] TIME_MAX = TIME_MAX64[TIME_BITS-1:0];
	localparam logic [efrs_pkg::SZ_BITS-1:0] ROOMS_SZ = efrs_pkg::SZ_BITS'(ROOMS);

	efrs_pkg::state_t state_q;

	logic [efrs_pkg::CFG_BITS-1:0] num_rooms_q;

	// room memories and per-room valid bits
	logic [TIME_BITS-1:0]          free_mem [ROOMS];
	logic [efrs_pkg::CNT_BITS-1:0] cnt_mem  [ROOMS];
	logic [ROOMS-1:0]              room_ok_q;
	logic [TIME_BITS-1:0]          free_rd_q;
	logic [efrs_pkg::CNT_BITS-1:0] cnt_rd_q;
	logic                          rd_ok_q;
	logic [ROOM_BITS-1:0]          rd_addr;
	logic                          mem_we;

	// job registers
	logic [TIME_BITS-1:0]          start_q;
	logic [31:0]                   dur_q;
	logic                          last_q;
	logic [ROOM_BITS-1:0]          n_last_q;
	logic [ROOM_BITS-1:0]          scan_idx_q;

	// scan stage
	logic                          vld_s1;
	logic [ROOM_BITS-1:0]          idx_s1;
	logic                          found_q;
	logic [ROOM_BITS-1:0]          room_q;
	logic [TIME_BITS-1:0]          min_q;
	logic [ROOM_BITS-1:0]          min_idx_q;
	logic [efrs_pkg::CNT_BITS-1:0] best_cnt_q;
	logic [ROOM_BITS-1:0]          best_idx_q;
	logic [TIME_BITS-1:0]          begin_q;

	// combinational helpers
	logic [63:0]                   start64;
	logic [TIME_BITS-1:0]          start_sat;
	logic [efrs_pkg::SZ_BITS-1:0]  n_rooms;
	logic [efrs_pkg::SZ_BITS-1:0]  n_minus1;
	logic [TIME_BITS-1:0]          rd_free;
	logic [efrs_pkg::CNT_BITS-1:0] rd_cnt;
	logic [ROOM_BITS-1:0]          pick_room;
	logic [TIME_BITS-1:0]          pick_begin;
	logic [SUM_W-1:0]              fin_sum;
	logic [TIME_BITS-1:0]          finish;
	logic [efrs_pkg::CNT_BITS-1:0] cnt_new;
	logic [ROOM_BITS-1:0]          busiest;
	logic                          out_free;
	logic                          upd_go;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != efrs_pkg::ST_IDLE);
	assign out_free  = !out_valid || !out_stall;
	assign upd_go    = (state_q == efrs_pkg::ST_UPD) && out_free;
	assign mem_we    = upd_go;

	// saturate start into the time range, clamp the room count
	assign start64   = {32'd0, start_time};
	assign start_sat = (start64 > TIME_MAX64) ? TIME_MAX : start64[TIME_BITS-1:0];

	always_comb begin
		priority if (num_rooms_q == '0) begin
			n_rooms = efrs_pkg::SZ_BITS'(1);
		end else if (efrs_pkg::SZ_BITS'(num_rooms_q) > ROOMS_SZ) begin
			n_rooms = ROOMS_SZ;
		end else begin
			n_rooms = efrs_pkg::SZ_BITS'(num_rooms_q);
		end
		n_minus1 = n_rooms - efrs_pkg::SZ_BITS'(1);
	end

	// rooms never written since the last clear read as zero
	assign rd_free = rd_ok_q ? free_rd_q : '0;
	assign rd_cnt  = rd_ok_q ? cnt_rd_q : '0;

	assign pick_room  = found_q ? room_q : min_idx_q;
	assign pick_begin = found_q ? start_q : min_q;

	always_comb begin
		unique case (state_q)
			efrs_pkg::ST_SCAN: rd_addr = scan_idx_q;
			efrs_pkg::ST_PICK: rd_addr = pick_room;
			default:           rd_addr = room_q;
		endcase
	end

	assign fin_sum = SUM_W'(begin_q) + SUM_W'(dur_q);
	assign finish  = (fin_sum > SUM_W'(TIME_MAX64)) ? TIME_MAX : fin_sum[TIME_BITS-1:0];
	assign cnt_new = (rd_cnt == efrs_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

	// busiest after the increment: only the chosen room's count has moved
	always_comb begin
		priority if (room_q == best_idx_q) begin
			busiest = best_idx_q;
		end else if ((cnt_new > best_cnt_q) ||
				((cnt_new == best_cnt_q) && (room_q < best_idx_q))) begin
			busiest = room_q;
		end else begin
			busiest = best_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			free_mem[room_q] <= finish;
			cnt_mem[room_q]  <= cnt_new;
		end
		free_rd_q <= free_mem[rd_addr];
		cnt_rd_q  <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_ok_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			rd_ok_q <= room_ok_q[rd_addr];
			if (mem_we) begin
				if (last_q) begin
					room_ok_q <= '0;
				end else begin
					room_ok_q[room_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rooms_q <= efrs_pkg::NUM_ROOMS_RST;
		end else if (cfg_valid && cfg_ready) begin
			num_rooms_q <= num_rooms;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= efrs_pkg::ST_IDLE;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			vld_s1 <= (state_q == efrs_pkg::ST_SCAN);
			unique case (state_q)
				efrs_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q    <= efrs_pkg::ST_SCAN;
						scan_idx_q <= '0;
						found_q    <= 1'b0;
					end
				end
				efrs_pkg::ST_SCAN: begin
					if (scan_idx_q == n_last_q) begin
						state_q <= efrs_pkg::ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				efrs_pkg::ST_DRAIN: state_q <= efrs_pkg::ST_PICK;
				efrs_pkg::ST_PICK:  state_q <= efrs_pkg::ST_UPD;
				efrs_pkg::ST_UPD: begin
					if (out_free) begin
						state_q <= efrs_pkg::ST_IDLE;
					end
				end
				default: state_q <= efrs_pkg::ST_IDLE;
			endcase
			if (vld_s1 && !found_q && (rd_free <= start_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	// job capture and scan datapath
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (state_q == efrs_pkg::ST_IDLE && in_valid) begin
			start_q  <= start_sat;
			dur_q    <= (end_time > start_time) ? end_time - start_time : 32'd0;
			last_q   <= last_meeting;
			n_last_q <= n_minus1[ROOM_BITS-1:0];
		end
		if (vld_s1) begin
			if (!found_q && (rd_free <= start_q)) begin
				room_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (rd_free < min_q)) begin
				min_q     <= rd_free;
				min_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (rd_cnt > best_cnt_q)) begin
				best_cnt_q <= rd_cnt;
				best_idx_q <= idx_s1;
			end
		end
		if (state_q == efrs_pkg::ST_PICK) begin
			room_q  <= pick_room;
			begin_q <= pick_begin;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (upd_go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			assigned_room <= room_q;
			begin_time    <= begin_q;
			finish_time   <= finish;
			busiest_room  <= last_q ? busiest : '0;
			batch_done    <= last_q;
		end
	end

endmodule
